/* sv/otgs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package otgs_pkg;

  localparam int SEGMENTS_DEF = 128;
  localparam int PAGES_DEF    = 8;

  localparam int PAGE_W    = 3;
  localparam int COL_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int ENTRY_W   = BYTE_W + 1;  // {is_data, byte_value}
  localparam int RUN_LEN   = 6;
  localparam int MAX_RUN   = 2 * RUN_LEN;
  localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_COUNT  = 95;
  localparam int GLYPH_IDX_W  = 7;

  localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
  localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;

  localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
  localparam logic [7:0] BLANK_COLUMN  = 8'h00;

  typedef enum logic [0:0] {
    OP_PRINT      = 1'b0,
    OP_SET_CURSOR = 1'b1
  } otgs_op_e;

  // one run of bytes for the serializer, entry 0 goes out first
  typedef struct packed {
    logic [MAX_RUN-1:0][ENTRY_W-1:0] entries;
    logic [RUN_CNT_W-1:0]            len;
  } otgs_run_t;

  // 5x7 font, column 0 in the top byte
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h1CA0A0A07C, 40'h4464544C44, 40'h00107C8200,
    40'h0000FF0000, 40'h00827C1000, 40'h0006090906
  };

endpackage

`default_nettype wire

/* sv/otgs_run_gen.sv */
`timescale 1ns / 1ps
`default_nettype none

module otgs_run_gen #(
  parameter int SEGMENTS = otgs_pkg::SEGMENTS_DEF,
  parameter int PAGES    = otgs_pkg::PAGES_DEF
) (
  input  var otgs_pkg::otgs_op_e                 opcode_i,
  input  var logic [7:0]                         char_code_i,
  input  var logic [7:0]                         target_page_i,
  input  var logic [7:0]                         target_column_i,
  input  var logic [otgs_pkg::PAGE_W-1:0]        page_i,
  input  var logic [otgs_pkg::COL_W-1:0]         column_i,
  output otgs_pkg::otgs_run_t                    run_o,
  output logic [otgs_pkg::PAGE_W-1:0]            page_o,
  output logic [otgs_pkg::COL_W-1:0]             column_o
);

  typedef logic [otgs_pkg::RUN_LEN-1:0][otgs_pkg::ENTRY_W-1:0] seg_t;

  // six command bytes that place the write window
  function automatic seg_t addr_run(logic [7:0] col, logic [7:0] page);
    seg_t r;
    r[0] = {1'b0, otgs_pkg::CMD_COL_ADDR};
    r[1] = {1'b0, col};
    r[2] = {1'b0, 8'(SEGMENTS - 1)};
    r[3] = {1'b0, otgs_pkg::CMD_PAGE_ADDR};
    r[4] = {1'b0, page};
    r[5] = {1'b0, 8'(PAGES - 1)};
    return r;
  endfunction

  logic                                newline;
  logic                                printable;
  logic                                overflow;
  logic                                wrap;
  logic                                in_range;
  logic [otgs_pkg::PAGE_W-1:0]         next_page;
  logic [otgs_pkg::GLYPH_IDX_W-1:0]    glyph_idx;
  logic [39:0]                         glyph_bits;
  seg_t                                glyph_seg;

  assign newline   = (char_code_i == otgs_pkg::NEWLINE_CODE);
  assign printable = (char_code_i >= otgs_pkg::FIRST_PRINTABLE) &&
                     (char_code_i <= otgs_pkg::LAST_PRINTABLE);
  assign overflow  = ({1'b0, column_i} + 9'(otgs_pkg::GLYPH_WIDTH)) >= 9'(SEGMENTS);
  assign wrap      = newline || overflow;
  assign in_range  = ({1'b0, target_page_i} < 9'(PAGES)) &&
                     ({1'b0, target_column_i} < 9'(SEGMENTS));
  assign next_page = (page_i == otgs_pkg::PAGE_W'(PAGES - 1)) ? '0 : page_i + 1'b1;

  // printable range is offset so the index stays below the glyph count
  assign glyph_idx  = otgs_pkg::GLYPH_IDX_W'(char_code_i - otgs_pkg::FIRST_PRINTABLE);
  assign glyph_bits = printable ? otgs_pkg::GLYPH_ROM[glyph_idx] : '0;

  always_comb begin
    for (int k = 0; k < otgs_pkg::GLYPH_WIDTH; k++) begin
      glyph_seg[k] = {1'b1, glyph_bits[39 - 8*k -: 8]};
    end
    glyph_seg[otgs_pkg::RUN_LEN-1] = {1'b1, otgs_pkg::BLANK_COLUMN};
  end

  always_comb begin
    run_o    = '0;
    page_o   = page_i;
    column_o = column_i;
    case (opcode_i)
      otgs_pkg::OP_SET_CURSOR: begin
        if (in_range) begin
          page_o   = otgs_pkg::PAGE_W'(target_page_i);
          column_o = target_column_i;
          run_o.entries[otgs_pkg::RUN_LEN-1:0] = addr_run(target_column_i, target_page_i);
          run_o.len = otgs_pkg::RUN_CNT_W'(otgs_pkg::RUN_LEN);
        end
      end
      otgs_pkg::OP_PRINT: begin
        if (wrap) begin
          page_o   = next_page;
          run_o.entries[otgs_pkg::RUN_LEN-1:0] = addr_run(8'h00, 8'(next_page));
          if (newline) begin
            column_o  = '0;
            run_o.len = otgs_pkg::RUN_CNT_W'(otgs_pkg::RUN_LEN);
          end else begin
            column_o  = otgs_pkg::COL_W'(otgs_pkg::RUN_LEN);
            run_o.entries[otgs_pkg::MAX_RUN-1:otgs_pkg::RUN_LEN] = glyph_seg;
            run_o.len = otgs_pkg::RUN_CNT_W'(otgs_pkg::MAX_RUN);
          end
        end else begin
          column_o  = column_i + otgs_pkg::COL_W'(otgs_pkg::RUN_LEN);
          run_o.entries[otgs_pkg::RUN_LEN-1:0] = glyph_seg;
          run_o.len = otgs_pkg::RUN_CNT_W'(otgs_pkg::RUN_LEN);
        end
      end
      default: begin
        run_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/oled_text_glyph_streamer_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Text renderer for a page-addressed monochrome OLED: each input transfer is
// either a character to print or a set-cursor request, and the block answers
// with the command and pixel bytes for the display, one byte per output
// transfer, tlast on the final byte of each item's run. A print of a normal
// character gives six data bytes (five font columns and a blank column); a
// newline, or a glyph that would not fit on the line, first moves to column 0
// of the next page and sends the six address commands; a set-cursor request
// in range sends the six commands and one out of range sends nothing. An item
// occupies the output for as many transfers as it has bytes: 6 or 12, so a
// full line wrap sends 12 bytes; an item with no bytes just retires. The
// output shift register delivers one byte per cycle while the receiver is
// ready. The next item is taken into the input register while the current
// run still drains, and its run is loaded in the cycle the last byte leaves,
// so the output never idles between items when input keeps up.
module oled_text_glyph_streamer_top #(
  parameter int SEGMENTS = otgs_pkg::SEGMENTS_DEF,
  parameter int PAGES    = otgs_pkg::PAGES_DEF
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // input items
  input  var logic        s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  var logic [23:0] s_axis_tdata_i,   // char_code, target_page, target_column
  input  var logic        s_axis_tuser_i,   // opcode
  // output bytes
  output logic            m_axis_tvalid_o,
  input  var logic        m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // byte_value
  output logic            m_axis_tuser_o,   // is_data
  output logic            m_axis_tlast_o    // last
);

  // input register
  logic                         in_valid_q, in_valid_d;
  otgs_pkg::otgs_op_e           in_op_q;
  logic [7:0]                   in_char_q, in_page_q, in_col_q;

  // cursor state
  logic [otgs_pkg::PAGE_W-1:0]  page_q, page_d;
  logic [otgs_pkg::COL_W-1:0]   col_q, col_d;

  // output shift register, entry 0 is the byte on the bus
  logic [otgs_pkg::MAX_RUN-1:0][otgs_pkg::ENTRY_W-1:0] buf_q, buf_d;
  logic [otgs_pkg::RUN_CNT_W-1:0]                      rem_q, rem_d;

  otgs_pkg::otgs_run_t          run;
  logic [otgs_pkg::PAGE_W-1:0]  run_page;
  logic [otgs_pkg::COL_W-1:0]   run_col;

  logic out_xfer;
  logic out_done;
  logic out_free;
  logic in_move;
  logic in_xfer;

  otgs_run_gen #(
    .SEGMENTS (SEGMENTS),
    .PAGES    (PAGES)
  ) u_run_gen (
    .opcode_i        (in_op_q),
    .char_code_i     (in_char_q),
    .target_page_i   (in_page_q),
    .target_column_i (in_col_q),
    .page_i          (page_q),
    .column_i        (col_q),
    .run_o           (run),
    .page_o          (run_page),
    .column_o        (run_col)
  );

  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign out_done = out_xfer && (rem_q == otgs_pkg::RUN_CNT_W'(1));
  // shift register can take a new run when empty or on its last transfer
  assign out_free = (rem_q == '0) || out_done;
  assign in_move  = in_valid_q && out_free;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = !in_valid_q || in_move;

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = buf_q[0][otgs_pkg::BYTE_W-1:0];
  assign m_axis_tuser_o  = buf_q[0][otgs_pkg::BYTE_W];
  assign m_axis_tlast_o  = (rem_q == otgs_pkg::RUN_CNT_W'(1));

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (in_move) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    page_d = page_q;
    col_d  = col_q;
    buf_d  = buf_q;
    rem_d  = rem_q;
    if (in_move) begin
      // runs of zero length just retire the item
      page_d = run_page;
      col_d  = run_col;
      buf_d  = run.entries;
      rem_d  = run.len;
    end else if (out_xfer) begin
      buf_d  = {otgs_pkg::ENTRY_W'(0), buf_q[otgs_pkg::MAX_RUN-1:1]};
      rem_d  = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      page_q     <= '0;
      col_q      <= '0;
      rem_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      page_q     <= page_d;
      col_q      <= col_d;
      rem_q      <= rem_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_op_q   <= otgs_pkg::otgs_op_e'(s_axis_tuser_i);
      in_char_q <= s_axis_tdata_i[7:0];
      in_page_q <= s_axis_tdata_i[15:8];
      in_col_q  <= s_axis_tdata_i[23:16];
    end
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire

/* sv/otgs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module otgs_checker #(
  parameter int PAGES = otgs_pkg::PAGES_DEF
) (
  input var logic       clk_i,
  input var logic       rst_ni,
  input var logic       m_axis_tvalid_o,
  input var logic       m_axis_tready_i,
  input var logic [7:0] m_axis_tdata_o,
  input var logic       m_axis_tuser_o,
  input var logic       m_axis_tlast_o
);

  // stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  // nothing offered while in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // a run ending in pixel data ends with the blank column
  a_data_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o && m_axis_tlast_o |-> m_axis_tdata_o == 8'h00)
    else $error("glyph run does not end in a blank column");

  // a run ending in commands ends with the last page number
  a_cmd_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o && m_axis_tlast_o |->
      m_axis_tdata_o == 8'(PAGES - 1))
    else $error("address run does not end with the page limit");

endmodule

bind oled_text_glyph_streamer_top otgs_checker #(
  .PAGES (PAGES)
) u_otgs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

/* bench/oled_text_glyph_streamer_top_test.sv */
`timescale 1ns / 1ps

package otgs_check_pkg;

  localparam int LINE_SEGMENTS = 128;
  localparam int LINE_PAGES    = 8;
  localparam int GLYPH_COLS    = 5;

  localparam logic [7:0] LF_CODE        = 8'h0A;
  localparam logic [7:0] PRINT_LO       = 8'h20;
  localparam logic [7:0] PRINT_HI       = 8'h7E;
  localparam logic [7:0] SET_COLUMN_CMD = 8'h21;
  localparam logic [7:0] SET_PAGE_CMD   = 8'h22;

  // five font columns per glyph, leftmost column in bits 39:32
  localparam logic [39:0] FONT_5X7 [95] = '{
    40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h1CA0A0A07C, 40'h4464544C44, 40'h00107C8200,
    40'h0000FF0000, 40'h00827C1000, 40'h0006090906
  };

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } disp_byte_t;

  class glyph_stream_board;
    logic [2:0] page_q;
    logic [7:0] column_q;
    disp_byte_t bytes_due[$];
    int         errors;

    function new();
      page_q   = '0;
      column_q = '0;
      errors   = 0;
    endfunction

    function void push_byte(logic is_data, logic [7:0] value);
      disp_byte_t b;
      b.is_data = is_data;
      b.value   = value;
      b.last    = 1'b0;
      bytes_due.push_back(b);
    endfunction

    function void push_address(logic [2:0] page, logic [7:0] column);
      push_byte(1'b0, SET_COLUMN_CMD);
      push_byte(1'b0, column);
      push_byte(1'b0, 8'(LINE_SEGMENTS - 1));
      push_byte(1'b0, SET_PAGE_CMD);
      push_byte(1'b0, {5'b0, page});
      push_byte(1'b0, 8'(LINE_PAGES - 1));
    endfunction

    // predict the bytes of one accepted item and advance the cursor
    function void note_input(otgs_pkg::otgs_op_e op, logic [7:0] code,
                             logic [7:0] page, logic [7:0] column);
      int         due_count;
      logic       newline;
      logic       printable;
      logic [39:0] cols;
      disp_byte_t tail;
      due_count = bytes_due.size();
      if (op == otgs_pkg::OP_SET_CURSOR) begin
        if (int'(page) < LINE_PAGES && int'(column) < LINE_SEGMENTS) begin
          page_q   = page[2:0];
          column_q = column;
          push_address(page_q, column_q);
        end
      end else begin
        newline = (code == LF_CODE);
        if (newline || int'(column_q) + GLYPH_COLS >= LINE_SEGMENTS) begin
          page_q   = 3'((int'(page_q) + 1) % LINE_PAGES);
          column_q = '0;
          push_address(page_q, 8'h00);
        end
        if (!newline) begin
          printable = (code >= PRINT_LO && code <= PRINT_HI);
          cols = printable ? FONT_5X7[code - PRINT_LO] : 40'h0;
          for (int k = 0; k < GLYPH_COLS; k++) begin
            push_byte(1'b1, cols[39 - 8*k -: 8]);
          end
          push_byte(1'b1, 8'h00);
          column_q = column_q + 8'd6;
        end
      end
      if (bytes_due.size() > due_count) begin
        tail = bytes_due.pop_back();
        tail.last = 1'b1;
        bytes_due.push_back(tail);
      end
    endfunction

    function void check_result(logic is_data, logic [7:0] value, logic last);
      disp_byte_t want;
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: is_data=%0b value=%02h last=%0b",
                 $time, is_data, value, last);
      end else begin
        want = bytes_due.pop_front();
        if (is_data !== want.is_data) begin
          errors++;
          $display("%0t: is_data mismatch: expected %0b actual %0b",
                   $time, want.is_data, is_data);
        end
        if (value !== want.value) begin
          errors++;
          $display("%0t: byte_value mismatch: expected %02h actual %02h",
                   $time, want.value, value);
        end
        if (last !== want.last) begin
          errors++;
          $display("%0t: last mismatch: expected %0b actual %0b",
                   $time, want.last, last);
        end
      end
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction
  endclass

endpackage

module oled_text_glyph_streamer_top_test;
  import otgs_check_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data = '0;   // char_code, target_page, target_column
  logic        s_user = 1'b0; // opcode
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;        // byte_value
  logic        m_user;        // is_data
  logic        m_last;        // last

  int send_idle = 0;
  int recv_idle = 0;

  glyph_stream_board board = new();

  oled_text_glyph_streamer_top #(
    .SEGMENTS(LINE_SEGMENTS),
    .PAGES   (LINE_PAGES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver side back pressure
  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_idle);
  end

  // output transfers
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      board.check_result(m_user, m_data, m_last);
    end
  end

  // one input transfer; entered and left at a falling edge
  task automatic send_item(otgs_pkg::otgs_op_e op, logic [7:0] code,
                           logic [7:0] page, logic [7:0] column);
    if ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {column, page, code};
    do @(posedge clk_i); while (!s_ready);
    board.note_input(op, code, page, column);
    @(negedge clk_i);
  endtask

  task automatic print_char(logic [7:0] code);
    send_item(otgs_pkg::OP_PRINT, code, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic set_cursor(logic [7:0] page, logic [7:0] column);
    send_item(otgs_pkg::OP_SET_CURSOR, 8'($urandom_range(255)), page, column);
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      print_char(8'($urandom_range(PRINT_HI, PRINT_LO)));
    end else if (pick < 65) begin
      print_char(8'($urandom_range(255)));
    end else if (pick < 73) begin
      print_char(LF_CODE);
    end else if (pick < 93) begin
      // bias toward the end of the line so that wraps show up often
      if ($urandom_range(1)) begin
        set_cursor(8'($urandom_range(LINE_PAGES - 1)), 8'($urandom_range(LINE_SEGMENTS - 1)));
      end else begin
        set_cursor(8'($urandom_range(LINE_PAGES - 1)),
                   8'($urandom_range(LINE_SEGMENTS - 1, LINE_SEGMENTS - 20)));
      end
    end else begin
      if ($urandom_range(1)) begin
        set_cursor(8'($urandom_range(255, LINE_PAGES)), 8'($urandom_range(255)));
      end else begin
        set_cursor(8'($urandom_range(255)), 8'($urandom_range(255, LINE_SEGMENTS)));
      end
    end
  endtask

  // stop sending until every predicted byte has gone out
  task automatic drain();
    s_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling on either side
    print_char(8'h41);
    print_char(PRINT_LO);
    print_char(PRINT_HI);
    print_char(8'h7F);               // just above the printable range
    print_char(8'h1F);               // just below it
    print_char(8'h00);
    print_char(8'hFF);
    print_char(LF_CODE);
    set_cursor(8'd0, 8'd0);
    set_cursor(8'(LINE_PAGES - 1), 8'(LINE_SEGMENTS - 1));
    print_char(8'h5A);               // line overflow on the last page wraps to page 0
    set_cursor(8'(LINE_PAGES), 8'd0);      // page out of range
    set_cursor(8'd0, 8'(LINE_SEGMENTS));   // column out of range
    set_cursor(8'hFF, 8'hFF);
    set_cursor(8'd3, 8'(LINE_SEGMENTS - 6));
    print_char(8'h61);               // fits exactly, column runs past the line
    print_char(8'h62);               // now overflows
    set_cursor(8'd5, 8'(LINE_SEGMENTS - 2));
    print_char(LF_CODE);             // newline and overflow together, one advance
    set_cursor(8'd2, 8'(LINE_SEGMENTS - 5));
    print_char(8'h80);               // overflow then blank glyph
    send_item(otgs_pkg::OP_PRINT, 8'h7E, 8'hFF, 8'hFF);
    send_item(otgs_pkg::OP_SET_CURSOR, 8'hFF, 8'd1, 8'd64);
    drain();

    send_idle = 14;
    recv_idle = 67;
    repeat (100) send_random_item();
    drain();

    send_idle = 67;
    recv_idle = 14;
    repeat (100) send_random_item();
    drain();

    send_idle = 0;
    recv_idle = 0;
    repeat (100) send_random_item();
    drain();

    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
